// File: rtl/core/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package rrts_pkg;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_SCHED  = 2'd1;
    localparam logic [1:0] OP_SLEEP  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_UNUSED   = 2'd0;
    localparam logic [1:0] ST_RUNNABLE = 2'd1;
    localparam logic [1:0] ST_RUNNING  = 2'd2;
    localparam logic [1:0] ST_SLEEPING = 2'd3;

    localparam logic [2:0] STATUS_OK    = 3'd0;
    localparam logic [2:0] STATUS_FULL  = 3'd1;
    localparam logic [2:0] STATUS_ALLOC = 3'd2;
    localparam logic [2:0] STATUS_IDLE  = 3'd3;
    localparam logic [2:0] STATUS_NOCUR = 3'd4;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 56;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan_inc;
        logic create_take;
        logic set_full;
        logic wake_chk;
        logic sleep_park;
        logic set_nocur;
        logic requeue;
        logic pop_rd;
        logic pop_take;
        logic pop_none;
        logic id_take;
        logic rep_zero;
        logic out_load;
    } rrts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       scan_last;
        logic       scan_unused;
        logic       cur_valid;
        logic       ready_empty;
        logic       out_busy;
    } rrts_sts_t;

endpackage

// File: rtl/core/round_robin_task_scheduler.sv
// Channel  Dir  Bits  Contents
// s_       in   72    operation, current_time, sleep_time, alloc_ok
// m_       out  56    status, slot, task_id, running_valid, create_count
//
// One operation at a time. Create scans slots one per cycle. Schedule, and sleep
// with a current task, read each slot's deadline from RAM in S_RD and compare it in
// S_CMP. The result register lets the next operation start while a result waits.
// Reset (aresetn low, synchronous) clears the slot table and queue pointers.
// Top level of the round-robin task scheduler. Depends on rrts_pkg, rrts_ctrl, rrts_dp.
module round_robin_task_scheduler #(
    parameter int TASK_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], current_time[33:2], sleep_time[65:34], alloc_ok[66]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], slot[6:3], task_id[38:7], running_valid[39], create_count[55:40]
    output logic [55:0] m_tdata
);
    import rrts_pkg::*;

    rrts_cmd_t cmd;
    rrts_sts_t sts;

    rrts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rrts_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );
endmodule

// File: rtl/core/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/rrts_ctrl.sv
// Sequencer for the task scheduler: steps each operation through the scan,
// queue and report phases that it needs. Depends on rrts_pkg.
module rrts_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rrts_pkg::rrts_sts_t sts,
    output rrts_pkg::rrts_cmd_t cmd
);
    import rrts_pkg::*;

    localparam logic [3:0] IDLE    = 4'd0;
    localparam logic [3:0] DISP    = 4'd1;
    localparam logic [3:0] C_SCAN  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_REQ   = 4'd5;
    localparam logic [3:0] S_POP   = 4'd6;
    localparam logic [3:0] S_POPW  = 4'd7;
    localparam logic [3:0] REPORT  = 4'd8;
    localparam logic [3:0] ID_W    = 4'd9;
    localparam logic [3:0] OUT     = 4'd10;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = DISP;
                end
            end
            DISP: begin
                case (sts.op)
                    OP_CREATE: state_next = C_SCAN;
                    OP_SCHED:  state_next = S_RD;
                    OP_SLEEP: begin
                        if (sts.cur_valid) begin
                            cmd.sleep_park = 1'b1;
                            state_next     = S_RD;
                        end else begin
                            cmd.set_nocur = 1'b1;
                            state_next    = REPORT;
                        end
                    end
                    default: state_next = REPORT;
                endcase
            end
            C_SCAN: begin
                if (sts.scan_unused) begin
                    cmd.create_take = 1'b1;
                    state_next      = OUT;
                end else if (sts.scan_last) begin
                    cmd.set_full = 1'b1;
                    state_next   = OUT;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_RD: state_next = S_CMP;
            S_CMP: begin
                cmd.wake_chk = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_REQ;
                end else begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_REQ: begin
                cmd.requeue = 1'b1;
                state_next  = S_POP;
            end
            S_POP: begin
                if (sts.ready_empty) begin
                    cmd.pop_none = 1'b1;
                    state_next   = REPORT;
                end else begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW: begin
                cmd.pop_take = 1'b1;
                state_next   = REPORT;
            end
            REPORT: begin
                if (sts.cur_valid) begin
                    state_next = ID_W;
                end else begin
                    cmd.rep_zero = 1'b1;
                    state_next   = OUT;
                end
            end
            ID_W: begin
                cmd.id_take = 1'b1;
                state_next  = OUT;
            end
            OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end
endmodule

// File: rtl/core/rrts_dp.sv
// Datapath of the task scheduler: slot table, ready queue, current task,
// counters and the result register. Depends on rrts_pkg and rrts_ram.
module rrts_dp #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rrts_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rrts_pkg::M_DATA_W-1:0]   m_tdata,
    input  rrts_pkg::rrts_cmd_t             cmd,
    output rrts_pkg::rrts_sts_t             sts
);
    import rrts_pkg::*;

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int CW = SW + 1;
    localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);

    logic [1:0]    op_reg, op_next;
    logic [31:0]   now_reg, now_next;
    logic [31:0]   dur_reg, dur_next;
    logic          alloc_reg, alloc_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic [1:0]    slot_state_reg [TASK_SLOTS];
    logic [1:0]    slot_state_next [TASK_SLOTS];
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [31:0]   next_id_reg, next_id_next;
    logic [15:0]   created_reg, created_next;
    logic [2:0]    status_reg, status_next;
    logic [SW-1:0] rslot_reg, rslot_next;
    logic [31:0]   rid_reg, rid_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic          push;
    logic [SW-1:0] push_slot;
    logic [31:0]   id_q, dl_q;
    logic [SW-1:0] fifo_q;
    logic [32:0]   dl_sum;
    logic [31:0]   dl_sat;
    logic [SW+3:0] rslot_wide;

    assign dl_sum = {1'b0, now_reg} + {1'b0, dur_reg};
    assign dl_sat = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
    assign rslot_wide = {4'b0, rslot_reg};

    rrts_ram #(.WIDTH(32), .DEPTH(TASK_SLOTS)) u_id_ram (
        .aclk (aclk),
        .we   (cmd.create_take),
        .waddr(scan_reg),
        .wdata(next_id_reg),
        .raddr(cur_reg),
        .rdata(id_q)
    );

    rrts_ram #(.WIDTH(32), .DEPTH(TASK_SLOTS)) u_dl_ram (
        .aclk (aclk),
        .we   (cmd.sleep_park),
        .waddr(cur_reg),
        .wdata(dl_sat),
        .raddr(scan_reg),
        .rdata(dl_q)
    );

    rrts_ram #(.WIDTH(SW), .DEPTH(TASK_SLOTS)) u_fifo_ram (
        .aclk (aclk),
        .we   (push),
        .waddr(tail_reg),
        .wdata(push_slot),
        .raddr(head_reg),
        .rdata(fifo_q)
    );

    always_comb begin
        op_next        = op_reg;
        now_next       = now_reg;
        dur_next       = dur_reg;
        alloc_next     = alloc_reg;
        scan_next      = scan_reg;
        slot_state_next = slot_state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        next_id_next   = next_id_reg;
        created_next   = created_reg;
        status_next    = status_reg;
        rslot_next     = rslot_reg;
        rid_next       = rid_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        push           = 1'b0;
        push_slot      = scan_reg;

        if (cmd.load) begin
            op_next     = s_tdata[1:0];
            now_next    = s_tdata[33:2];
            dur_next    = s_tdata[65:34];
            alloc_next  = s_tdata[66];
            scan_next   = '0;
            status_next = STATUS_OK;
        end
        if (cmd.scan_inc) begin
            scan_next = scan_reg + SW'(1);
        end
        if (cmd.create_take) begin
            if (created_reg != 16'hFFFF) begin
                created_next = created_reg + 16'd1;
            end
            next_id_next = next_id_reg + 32'd1;
            rslot_next   = scan_reg;
            rid_next     = next_id_reg;
            if (alloc_reg) begin
                slot_state_next[scan_reg] = ST_RUNNABLE;
                push        = 1'b1;
                status_next = STATUS_OK;
            end else begin
                status_next = STATUS_ALLOC;
            end
        end
        if (cmd.set_full) begin
            status_next = STATUS_FULL;
            rslot_next  = '0;
            rid_next    = '0;
        end
        if (cmd.sleep_park) begin
            slot_state_next[cur_reg] = ST_SLEEPING;
        end
        if (cmd.set_nocur) begin
            status_next = STATUS_NOCUR;
        end
        if (cmd.wake_chk && slot_state_reg[scan_reg] == ST_SLEEPING && dl_q <= now_reg) begin
            slot_state_next[scan_reg] = ST_RUNNABLE;
            push = 1'b1;
        end
        if (cmd.requeue && cur_valid_reg && slot_state_reg[cur_reg] == ST_RUNNING) begin
            slot_state_next[cur_reg] = ST_RUNNABLE;
            push      = 1'b1;
            push_slot = cur_reg;
        end
        // a full queue drops the push
        if (push && count_reg < CW'(TASK_SLOTS)) begin
            tail_next  = (tail_reg == LAST) ? '0 : tail_reg + SW'(1);
            count_next = count_reg + CW'(1);
        end else begin
            push = 1'b0;
        end
        if (cmd.pop_rd) begin
            head_next  = (head_reg == LAST) ? '0 : head_reg + SW'(1);
            count_next = count_reg - CW'(1);
        end
        if (cmd.pop_take) begin
            slot_state_next[fifo_q] = ST_RUNNING;
            cur_next       = fifo_q;
            cur_valid_next = 1'b1;
            status_next    = STATUS_OK;
        end
        if (cmd.pop_none) begin
            if (cur_valid_reg && slot_state_reg[cur_reg] == ST_RUNNABLE) begin
                slot_state_next[cur_reg] = ST_RUNNING;
                status_next = STATUS_OK;
            end else begin
                cur_valid_next = 1'b0;
                status_next    = STATUS_IDLE;
            end
        end
        if (cmd.id_take) begin
            rslot_next = cur_reg;
            rid_next   = id_q;
        end
        if (cmd.rep_zero) begin
            rslot_next = '0;
            rid_next   = '0;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {created_reg, cur_valid_reg, rid_reg, rslot_wide[3:0], status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            next_id_reg   <= 32'd1;
            created_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                slot_state_reg[i] <= ST_UNUSED;
            end
        end else begin
            scan_reg       <= scan_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            cur_reg        <= cur_next;
            cur_valid_reg  <= cur_valid_next;
            next_id_reg    <= next_id_next;
            created_reg    <= created_next;
            m_tvalid_reg   <= m_tvalid_next;
            slot_state_reg <= slot_state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        now_reg     <= now_next;
        dur_reg     <= dur_next;
        alloc_reg   <= alloc_next;
        status_reg  <= status_next;
        rslot_reg   <= rslot_next;
        rid_reg     <= rid_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign sts.op          = op_reg;
    assign sts.scan_last   = (scan_reg == LAST);
    assign sts.scan_unused = (slot_state_reg[scan_reg] == ST_UNUSED);
    assign sts.cur_valid   = cur_valid_reg;
    assign sts.ready_empty = (count_reg == '0);
    assign sts.out_busy    = m_tvalid_reg;
endmodule

// File: rtl/core/rrts_checker.sv
// Port-level checks for the task scheduler, bound to the top level.
// Depends on rrts_pkg and round_robin_task_scheduler.
module rrts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    import rrts_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= STATUS_NOCUR)
        else $error("status code out of range");

    a_no_task: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[39] && m_tdata[2:0] != STATUS_ALLOC
            && m_tdata[2:0] != STATUS_OK |-> m_tdata[38:3] == '0)
        else $error("slot or id reported without a task");

    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == STATUS_IDLE || m_tdata[2:0] == STATUS_NOCUR)
            |-> !m_tdata[39])
        else $error("idle or no-task result with running task");

    a_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while busy");
endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
